// ===== design/tlac_pkg.sv =====
// ----------------------------------------------------------------------------
// tlac_pkg: shared types and constants of the answer cache
// entry layout, cell control and register defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlac_pkg;

  localparam int unsigned DefEntries = 64;

  localparam int unsigned TagW  = 64;
  localparam int unsigned TimeW = 32;
  localparam int unsigned ExpW  = 33;
  localparam int unsigned TtlW  = 31;
  localparam int unsigned HdlW  = 32;
  localparam int unsigned LenW  = 16;
  localparam int unsigned IdxW  = 8;
  localparam int unsigned DataW = 32;

  localparam logic [TtlW-1:0] TtlCapRst = TtlW'(300);
  localparam logic [TtlW-1:0] NegTtlRst = TtlW'(30);

  // register indexes
  localparam logic [IdxW-1:0] RegTtlCap = IdxW'(0);
  localparam logic [IdxW-1:0] RegNegTtl = IdxW'(1);

  typedef struct packed {
    logic [HdlW-1:0] handle;
    logic [LenW-1:0] length;
    logic            negative;
  } record_t;

  typedef struct packed {
    logic             valid;
    logic [TagW-1:0]  tag;
    logic [ExpW-1:0]  expiry;
    record_t          first;
    record_t          second;
  } entry_t;

  // per-cycle command to every cell
  typedef struct packed {
    logic rotate;
    logic insert;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/tlac_cell.sv =====
// ----------------------------------------------------------------------------
// tlac_cell: one entry of the recency chain
// rotates with its neighbor, or shifts on insert while all cells before it are live
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlac_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  tlac_pkg::cell_ctrl_t ctrl_i,
  input  tlac_pkg::entry_t     prev_i,
  input  wire                  shift_i,
  output tlac_pkg::entry_t     entry_o,
  output logic                 shift_o
);

  logic                          valid_q;
  logic [tlac_pkg::TagW-1:0]     tag_q;
  logic [tlac_pkg::ExpW-1:0]     expiry_q;
  tlac_pkg::record_t             first_q;
  tlac_pkg::record_t             second_q;
  logic                          load;

  assign load    = ctrl_i.rotate | (ctrl_i.insert & shift_i);
  // insert ripples up to the first free cell
  assign shift_o = shift_i & valid_q;

  always_comb begin
    entry_o.valid  = valid_q;
    entry_o.tag    = tag_q;
    entry_o.expiry = expiry_q;
    entry_o.first  = first_q;
    entry_o.second = second_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tag_q    <= prev_i.tag;
      expiry_q <= prev_i.expiry;
      first_q  <= prev_i.first;
      second_q <= prev_i.second;
    end
  end

endmodule

`default_nettype wire

// ===== design/ttl_lru_answer_cache_unit.sv =====
// ----------------------------------------------------------------------------
// ttl_lru_answer_cache_unit: answer cache with lru replacement and ttl expiry
// a ring of entry cells ordered by recency, scanned once per transaction
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | content
//  in      | input     | in_valid_i / in_stall_o  | mode, tag, time, two records
//  out     | output    | out_valid_o / out_stall_i| hit flag and stored records
//  cfg     | input     | cfg_valid_i / cfg_ready_o| register index and data
//
// a transaction is taken in idle, then passes the ring and waits in done for the output:
// the ring rotates once past the tail check, every cell in turn
// a put adds an insert state that shifts new data in at the most recent end
// the next transaction is taken while a result still waits on out_stall_i
// reset empties every cell at once; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module ttl_lru_answer_cache_unit #(
  parameter int unsigned ENTRIES = tlac_pkg::DefEntries
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // request channel
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          mode_i,
  input  wire  [tlac_pkg::TagW-1:0]    name_tag_i,
  input  wire  [tlac_pkg::TimeW-1:0]   now_seconds_i,
  input  wire  [tlac_pkg::HdlW-1:0]    first_handle_i,
  input  wire  [tlac_pkg::LenW-1:0]    first_length_i,
  input  wire                          first_negative_i,
  input  wire  signed [31:0]           first_ttl_i,
  input  wire  [tlac_pkg::HdlW-1:0]    second_handle_i,
  input  wire  [tlac_pkg::LenW-1:0]    second_length_i,
  input  wire                          second_negative_i,
  input  wire  signed [31:0]           second_ttl_i,
  // result channel
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         hit_o,
  output logic [tlac_pkg::HdlW-1:0]    hit_first_handle_o,
  output logic [tlac_pkg::LenW-1:0]    hit_first_length_o,
  output logic                         hit_first_negative_o,
  output logic [tlac_pkg::HdlW-1:0]    hit_second_handle_o,
  output logic [tlac_pkg::LenW-1:0]    hit_second_length_o,
  output logic                         hit_second_negative_o,
  // configuration channel
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [tlac_pkg::IdxW-1:0]    cfg_index_i,
  input  wire  [tlac_pkg::DataW-1:0]   cfg_data_i
);

  localparam int unsigned CntW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PASS,
    S_INS,
    S_DONE
  } state_e;

  state_e state_q;
  logic [CntW-1:0] cnt_q;

  // configuration
  logic [tlac_pkg::TtlW-1:0] ttl_cap_q, neg_ttl_q;

  // transaction held for the whole pass
  logic                       mode_q;
  logic [tlac_pkg::TagW-1:0]  tag_q;
  logic [tlac_pkg::TimeW-1:0] now_q;
  logic [tlac_pkg::TtlW-1:0]  ttl_q;
  tlac_pkg::record_t          rec1_q, rec2_q;

  // result under construction and result on the port
  logic              wk_hit_q;
  tlac_pkg::record_t wk_first_q, wk_second_q;
  logic              res_hit_q;
  tlac_pkg::record_t res_first_q, res_second_q;
  logic              out_valid_q;

  // the ring
  tlac_pkg::entry_t     cell_q [ENTRIES];
  tlac_pkg::entry_t     prev   [ENTRIES];
  logic [ENTRIES:0]     shift;
  tlac_pkg::cell_ctrl_t ctrl;

  tlac_pkg::entry_t tail, tail_kept, new_entry, head_in;
  logic             tail_expired, tail_match, tail_drop;
  logic             accept, finish, out_free;

  // lifetime of a put
  logic signed [31:0]        ttl_pick;
  logic signed [32:0]        cap_s;
  logic [tlac_pkg::TtlW-1:0] ttl_d;

  assign accept      = in_valid_i & (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign finish      = (state_q == S_DONE) & out_free;

  always_comb begin
    cap_s = {2'b00, ttl_cap_q};
    if ((second_ttl_i > 0) && ((first_ttl_i <= 0) || (second_ttl_i < first_ttl_i))) begin
      ttl_pick = second_ttl_i;
    end else begin
      ttl_pick = first_ttl_i;
    end
    if ((ttl_pick <= 0) || ({ttl_pick[31], ttl_pick} > cap_s)) begin
      ttl_d = ttl_cap_q;
    end else begin
      ttl_d = ttl_pick[tlac_pkg::TtlW-1:0];
    end
    if (first_negative_i && second_negative_i) begin
      ttl_d = neg_ttl_q;
    end
  end

  // tail check: during a put, expired entries and the old copy of the put tag leave the ring
  assign tail         = cell_q[ENTRIES-1];
  assign tail_expired = ({1'b0, now_q} >= tail.expiry);
  assign tail_match   = (tail.tag == tag_q);
  assign tail_drop    = tail.valid & mode_q & (tail_expired | tail_match);

  always_comb begin
    tail_kept       = tail;
    tail_kept.valid = tail.valid & ~tail_drop;
  end

  always_comb begin
    new_entry.valid  = 1'b1;
    new_entry.tag    = tag_q;
    new_entry.expiry = {1'b0, now_q} + {2'b00, ttl_q};
    new_entry.first  = rec1_q;
    new_entry.second = rec2_q;
  end

  assign head_in     = (state_q == S_INS) ? new_entry : tail_kept;
  assign ctrl.rotate = (state_q == S_PASS);
  assign ctrl.insert = (state_q == S_INS);
  assign shift[0]    = 1'b1;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign prev[k] = head_in;
    end else begin : g_body
      assign prev[k] = cell_q[k-1];
    end
    tlac_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .prev_i  (prev[k]),
      .shift_i (shift[k]),
      .entry_o (cell_q[k]),
      .shift_o (shift[k+1])
    );
  end

  // control, configuration and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ttl_cap_q   <= tlac_pkg::TtlCapRst;
      neg_ttl_q   <= tlac_pkg::NegTtlRst;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == tlac_pkg::RegTtlCap) begin
          ttl_cap_q <= cfg_data_i[tlac_pkg::TtlW-1:0];
        end else if (cfg_index_i == tlac_pkg::RegNegTtl) begin
          neg_ttl_q <= cfg_data_i[tlac_pkg::TtlW-1:0];
        end
      end
      // a finishing transaction refills the output as the old result leaves
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_PASS;
            cnt_q   <= '0;
          end
        end
        S_PASS: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LastCnt) begin
            state_q <= mode_q ? S_INS : S_DONE;
          end
        end
        S_INS: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (finish) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // transaction capture and hit collection
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q          <= mode_i;
      tag_q           <= name_tag_i;
      now_q           <= now_seconds_i;
      ttl_q           <= ttl_d;
      rec1_q.handle   <= (first_length_i == '0) ? '0 : first_handle_i;
      rec1_q.length   <= first_length_i;
      rec1_q.negative <= first_negative_i;
      rec2_q.handle   <= (second_length_i == '0) ? '0 : second_handle_i;
      rec2_q.length   <= second_length_i;
      rec2_q.negative <= second_negative_i;
      wk_hit_q        <= 1'b0;
      wk_first_q      <= '0;
      wk_second_q     <= '0;
    end else if ((state_q == S_PASS) && !mode_q && tail.valid && tail_match
                 && !tail_expired) begin
      wk_hit_q    <= 1'b1;
      wk_first_q  <= tail.first;
      wk_second_q <= tail.second;
    end
    if (finish) begin
      res_hit_q    <= wk_hit_q;
      res_first_q  <= wk_first_q;
      res_second_q <= wk_second_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign hit_o                 = res_hit_q;
  assign hit_first_handle_o    = res_first_q.handle;
  assign hit_first_length_o    = res_first_q.length;
  assign hit_first_negative_o  = res_first_q.negative;
  assign hit_second_handle_o   = res_second_q.handle;
  assign hit_second_length_o   = res_second_q.length;
  assign hit_second_negative_o = res_second_q.negative;

endmodule

`default_nettype wire
